/* hw/rtl/sawlc_pkg.sv */
// Shared types and constants for the set-associative write-back LRU cache level.
// Holds the request/response payloads, per-way metadata and configuration codes.
// No dependencies.
package sawlc_pkg;

    // Fixed widths of the channel fields.
    localparam int ADDR_W = 48;
    localparam int RANK_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    // Default sizing of the storage.
    localparam int DEF_ADDR_BITS = 48;
    localparam int DEF_MAX_SETS = 1024;
    localparam int DEF_MAX_WAYS = 16;

    // Reset values of the configuration registers.
    localparam logic [3:0] RST_BLOCK_OFFSET_BITS = 4'd6;
    localparam logic [3:0] RST_SET_INDEX_BITS = 4'd10;
    localparam logic [2:0] RST_WAY_SELECT_BITS = 3'd2;

    // Rank given to every way after reset; rank 0 is the most recently used.
    localparam logic [RANK_W-1:0] RANK_OLDEST = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_OFFSET = 2'd0,
        CFG_SET_INDEX = 2'd1,
        CFG_WAY_SELECT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic is_write;
        logic [ADDR_W-1:0] access_address;
    } t_cache_req;

    typedef struct packed {
        logic hit;
        logic writeback_valid;
        logic [ADDR_W-1:0] writeback_address;
    } t_cache_rsp;

    typedef struct packed {
        logic valid;
        logic dirty;
        logic [RANK_W-1:0] rank;
    } t_way_meta;

    typedef struct packed {
        logic hit;
        logic writeback;
    } t_eval_flags;

endpackage

/* hw/rtl/sawlc_set_eval.sv */
// Lookup and replacement logic for one cache set: tag match, LRU victim choice
// and the updated metadata row. Depends on sawlc_pkg.
module sawlc_set_eval #(
    parameter int NWAYS = 4,
    parameter int ADDR_BITS = sawlc_pkg::DEF_ADDR_BITS
) (
    input  logic [NWAYS-1:0]                 i_use,
    input  logic                             i_is_write,
    input  logic [ADDR_BITS-1:0]             i_tag,
    input  logic [NWAYS-1:0][ADDR_BITS-1:0]  i_tags,
    input  sawlc_pkg::t_way_meta [NWAYS-1:0] i_meta,
    output sawlc_pkg::t_way_meta [NWAYS-1:0] o_meta,
    output logic [NWAYS-1:0]                 o_fill,
    output logic [ADDR_BITS-1:0]             o_victim_tag,
    output sawlc_pkg::t_eval_flags           o_flags
);
    import sawlc_pkg::*;

    logic [NWAYS-1:0] hit_vec;
    logic [NWAYS-1:0] hit_1h;
    logic [NWAYS-1:0] oldest;
    logic [NWAYS-1:0] victim_1h;
    logic [NWAYS-1:0] touch_1h;
    logic hit;
    logic victim_dirty;
    logic [RANK_W-1:0] old_rank;

    always_comb begin
        for (int w = 0; w < NWAYS; w++) begin
            hit_vec[w] = i_use[w] & i_meta[w].valid & (i_tags[w] == i_tag);
        end
    end

    // Lowest matching way wins if a configuration change left duplicates.
    assign hit_1h = hit_vec & (~hit_vec + NWAYS'(1));
    assign hit = |hit_vec;

    // A way is a victim candidate if no way in use is strictly older.
    always_comb begin
        for (int w = 0; w < NWAYS; w++) begin
            oldest[w] = i_use[w];
            for (int v = 0; v < NWAYS; v++) begin
                if (i_use[v] && (i_meta[v].rank > i_meta[w].rank)) begin
                    oldest[w] = 1'b0;
                end
            end
        end
    end

    assign victim_1h = oldest & (~oldest + NWAYS'(1));
    assign touch_1h = hit ? hit_1h : victim_1h;

    always_comb begin
        old_rank = '0;
        o_victim_tag = '0;
        victim_dirty = 1'b0;
        for (int w = 0; w < NWAYS; w++) begin
            if (touch_1h[w]) begin
                old_rank = old_rank | i_meta[w].rank;
            end
            if (victim_1h[w]) begin
                o_victim_tag = o_victim_tag | i_tags[w];
                victim_dirty = victim_dirty | (i_meta[w].valid & i_meta[w].dirty);
            end
        end
    end

    always_comb begin
        for (int w = 0; w < NWAYS; w++) begin
            o_meta[w] = i_meta[w];
            if (touch_1h[w]) begin
                o_meta[w].rank = '0;
                if (hit) begin
                    o_meta[w].dirty = i_meta[w].dirty | i_is_write;
                end else begin
                    o_meta[w].valid = 1'b1;
                    o_meta[w].dirty = i_is_write;
                end
            end else if (i_use[w] && (i_meta[w].rank < old_rank)) begin
                o_meta[w].rank = i_meta[w].rank + RANK_W'(1);
            end
        end
    end

    assign o_fill = hit ? '0 : victim_1h;
    assign o_flags.hit = hit;
    assign o_flags.writeback = ~hit & victim_dirty;

endmodule

/* hw/rtl/set_assoc_writeback_lru_cache_level_unit.sv */
// Top level of one set-associative, write-back, write-allocate LRU cache level.
// Holds the tag and metadata memories, configuration registers and sequencing.
// Depends on sawlc_pkg and sawlc_set_eval.

// On acceptance of an access the set row is read from the tag and metadata
// memories into row registers; in the evaluate state the row is compared and the
// LRU victim chosen, and when the response register can take a new response the
// row is written back and the response registered. A new access is taken only
// after the previous one has left the evaluate state, so a full, unread response
// holds off the next access. After reset the metadata memory is cleared one set
// per cycle, 2^floor(log2(MAX_SETS)) sets (1024 with the defaults), and no access
// is accepted until that pass ends. Configuration writes are accepted at any time
// but must only be issued while no transaction is in flight.
module set_assoc_writeback_lru_cache_level_unit #(
    parameter int ADDR_BITS = sawlc_pkg::DEF_ADDR_BITS,
    parameter int MAX_SETS = sawlc_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS = sawlc_pkg::DEF_MAX_WAYS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  sawlc_pkg::t_cache_req            i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output sawlc_pkg::t_cache_rsp            o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sawlc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sawlc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sawlc_pkg::*;

    localparam int SET_LOG = $clog2(MAX_SETS + 1) - 1;
    localparam int NROWS = 1 << SET_LOG;
    localparam int SET_AW = (SET_LOG > 0) ? SET_LOG : 1;
    localparam int WAY_LOG = $clog2(MAX_WAYS + 1) - 1;
    localparam int NWAYS = 1 << WAY_LOG;
    localparam int WCNT_W = WAY_LOG + 1;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE = 3'b010,
        S_EVAL = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [SET_AW-1:0] r_clr, n_clr;

    logic [3:0] r_blk_bits;
    logic [3:0] r_set_bits;
    logic [2:0] r_way_bits;

    logic [NWAYS-1:0][ADDR_BITS-1:0] r_tag_mem [NROWS];
    t_way_meta [NWAYS-1:0] r_meta_mem [NROWS];
    logic [NWAYS-1:0][ADDR_BITS-1:0] r_tag_row;
    t_way_meta [NWAYS-1:0] r_meta_row;

    logic r_wr;
    logic [SET_AW-1:0] r_set;
    logic [ADDR_BITS-1:0] r_tag;

    logic r_out_valid, n_out_valid;
    t_cache_rsp r_out_data;

    logic accept;
    logic advance;
    logic [4:0] ib;
    logic [2:0] sb;
    logic [WCNT_W-1:0] way_cnt;
    logic [NWAYS-1:0] use_mask;
    logic [ADDR_BITS-1:0] addr_in;
    logic [ADDR_BITS-1:0] set_full;
    logic [SET_AW-1:0] set_mask;
    logic [SET_AW-1:0] set_in;
    logic [ADDR_BITS-1:0] tag_in;

    t_way_meta [NWAYS-1:0] new_meta;
    t_way_meta [NWAYS-1:0] clr_row;
    logic [NWAYS-1:0] fill;
    logic [ADDR_BITS-1:0] victim_tag;
    t_eval_flags flags;
    logic [NWAYS-1:0][ADDR_BITS-1:0] new_tags;
    logic [ADDR_BITS-1:0] wb_addr;

    logic meta_we;
    logic [SET_AW-1:0] meta_wa;
    t_way_meta [NWAYS-1:0] meta_wd;
    logic tag_we;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept = i_in_valid & o_in_ready;
    assign advance = (r_state == S_EVAL) & (~r_out_valid | i_out_ready);

    // Set-index and way-select sizes are clamped to what the storage can hold.
    assign ib = ({1'b0, r_set_bits} > 5'(SET_LOG)) ? 5'(SET_LOG) : {1'b0, r_set_bits};
    assign sb = (r_way_bits > 3'(WAY_LOG)) ? 3'(WAY_LOG) : r_way_bits;
    assign way_cnt = WCNT_W'(1) << sb;
    assign use_mask = ~({NWAYS{1'b1}} << way_cnt);

    assign addr_in = ADDR_BITS'(i_in_data.access_address);
    assign set_full = addr_in >> r_blk_bits;
    assign set_mask = ~({SET_AW{1'b1}} << ib);
    assign set_in = SET_AW'(set_full) & set_mask;
    assign tag_in = addr_in >> (6'(r_blk_bits) + 6'(ib));

    sawlc_set_eval #(
        .NWAYS(NWAYS),
        .ADDR_BITS(ADDR_BITS)
    ) u_set_eval (
        .i_use(use_mask),
        .i_is_write(r_wr),
        .i_tag(r_tag),
        .i_tags(r_tag_row),
        .i_meta(r_meta_row),
        .o_meta(new_meta),
        .o_fill(fill),
        .o_victim_tag(victim_tag),
        .o_flags(flags)
    );

    assign wb_addr = ((victim_tag << ib) | ADDR_BITS'(r_set)) << r_blk_bits;

    always_comb begin
        for (int w = 0; w < NWAYS; w++) begin
            new_tags[w] = fill[w] ? r_tag : r_tag_row[w];
            clr_row[w].valid = 1'b0;
            clr_row[w].dirty = 1'b0;
            clr_row[w].rank = RANK_OLDEST;
        end
    end

    assign meta_we = (r_state == S_CLEAR) | advance;
    assign meta_wa = (r_state == S_CLEAR) ? r_clr : r_set;
    assign meta_wd = (r_state == S_CLEAR) ? clr_row : new_meta;
    assign tag_we = advance & ~flags.hit;

    // Set memories: one write and one registered read per cycle, never the same cycle.
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_wa] <= meta_wd;
        end
        if (tag_we) begin
            r_tag_mem[r_set] <= new_tags;
        end
        if (accept) begin
            r_meta_row <= r_meta_mem[set_in];
            r_tag_row <= r_tag_mem[set_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wr <= i_in_data.is_write;
            r_set <= set_in;
            r_tag <= tag_in;
        end
        if (advance) begin
            r_out_data.hit <= flags.hit;
            r_out_data.writeback_valid <= flags.writeback;
            r_out_data.writeback_address <= flags.writeback ? ADDR_W'(wb_addr) : '0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + SET_AW'(1);
                if (r_clr == SET_AW'(NROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (advance) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid & ~i_out_ready;
        if (advance) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_bits <= RST_BLOCK_OFFSET_BITS;
            r_set_bits <= RST_SET_INDEX_BITS;
            r_way_bits <= RST_WAY_SELECT_BITS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BLOCK_OFFSET: r_blk_bits <= i_cfg_data[3:0];
                CFG_SET_INDEX: r_set_bits <= i_cfg_data[3:0];
                CFG_WAY_SELECT: r_way_bits <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;

endmodule

/* verif/sawlc_access_checker.sv */
// Checker for the set-associative write-back LRU cache level: it watches the
// request, response and configuration channels, keeps a shadow of the cache state
// and compares every response with its prediction. Depends on sawlc_pkg.
module sawlc_access_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  sawlc_pkg::t_cache_req            i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  sawlc_pkg::t_cache_rsp            i_out_data,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [sawlc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sawlc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_hit_count,
    output int                               o_miss_count,
    output int                               o_evict_count
);
    import sawlc_pkg::*;

    localparam int SET_BITS_MAX = $clog2(DEF_MAX_SETS);
    localparam int WAY_BITS_MAX = $clog2(DEF_MAX_WAYS);

    logic [ADDR_W-1:0] tag_mem [DEF_MAX_SETS][DEF_MAX_WAYS];
    bit                valid_mem [DEF_MAX_SETS][DEF_MAX_WAYS];
    bit                dirty_mem [DEF_MAX_SETS][DEF_MAX_WAYS];
    logic [RANK_W-1:0] rank_mem [DEF_MAX_SETS][DEF_MAX_WAYS];

    logic [3:0] blk_bits;
    logic [3:0] set_bits;
    logic [2:0] way_bits;

    t_cache_rsp expected_rsp_q [$];
    int fail_cnt = 0;
    int pend_cnt = 0;
    int hit_cnt = 0;
    int miss_cnt = 0;
    int evict_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending = pend_cnt;
    assign o_hit_count = hit_cnt;
    assign o_miss_count = miss_cnt;
    assign o_evict_count = evict_cnt;

    // The touched way becomes youngest; every way in use that was younger ages by one.
    task automatic bump_recency(input int set, input int way, input int ways);
        logic [RANK_W-1:0] old_rank;
        old_rank = rank_mem[set][way];
        for (int w = 0; w < ways; w++) begin
            if (w != way && rank_mem[set][w] < old_rank) begin
                rank_mem[set][w] = rank_mem[set][w] + 1'b1;
            end
        end
        rank_mem[set][way] = '0;
    endtask

    task automatic predict_access(input t_cache_req req);
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] tag;
        logic [63:0] rebuilt;
        logic [RANK_W-1:0] best;
        int b;
        int ib;
        int sb;
        int ways;
        int set;
        int way;
        int victim;
        bit found;
        t_cache_rsp rsp;
        addr = req.access_address;
        b = int'(blk_bits);
        ib = (int'(set_bits) > SET_BITS_MAX) ? SET_BITS_MAX : int'(set_bits);
        sb = (int'(way_bits) > WAY_BITS_MAX) ? WAY_BITS_MAX : int'(way_bits);
        ways = 1 << sb;
        set = int'((addr >> b) & ((48'd1 << ib) - 48'd1));
        tag = addr >> (b + ib);
        found = 1'b0;
        way = 0;
        rsp = '0;
        for (int w = 0; w < ways; w++) begin
            if (!found && valid_mem[set][w] && tag_mem[set][w] == tag) begin
                found = 1'b1;
                way = w;
            end
        end
        if (found) begin
            if (req.is_write) begin
                dirty_mem[set][way] = 1'b1;
            end
            bump_recency(set, way, ways);
            rsp.hit = 1'b1;
            hit_cnt++;
        end else begin
            // Oldest way is the victim; strict compare keeps the lowest way on ties.
            victim = 0;
            best = rank_mem[set][0];
            for (int w = 1; w < ways; w++) begin
                if (rank_mem[set][w] > best) begin
                    best = rank_mem[set][w];
                    victim = w;
                end
            end
            if (valid_mem[set][victim] && dirty_mem[set][victim]) begin
                rebuilt = ((64'(tag_mem[set][victim]) << ib) | 64'(set)) << b;
                rsp.writeback_valid = 1'b1;
                rsp.writeback_address = rebuilt[ADDR_W-1:0];
                evict_cnt++;
            end
            tag_mem[set][victim] = tag;
            valid_mem[set][victim] = 1'b1;
            dirty_mem[set][victim] = req.is_write;
            bump_recency(set, victim, ways);
            miss_cnt++;
        end
        expected_rsp_q.push_back(rsp);
        pend_cnt = expected_rsp_q.size();
    endtask

    task automatic check_rsp(input t_cache_rsp got);
        t_cache_rsp want;
        if (expected_rsp_q.size() == 0) begin
            $error("response transaction arrived with no access outstanding");
            fail_cnt++;
        end else begin
            want = expected_rsp_q.pop_front();
            pend_cnt = expected_rsp_q.size();
            if (got.hit !== want.hit) begin
                $error("hit: expected %0b, actual %0b", want.hit, got.hit);
                fail_cnt++;
            end
            if (got.writeback_valid !== want.writeback_valid) begin
                $error("writeback_valid: expected %0b, actual %0b",
                       want.writeback_valid, got.writeback_valid);
                fail_cnt++;
            end
            if (got.writeback_address !== want.writeback_address) begin
                $error("writeback_address: expected %h, actual %h",
                       want.writeback_address, got.writeback_address);
                fail_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DEF_MAX_SETS; s++) begin
                for (int w = 0; w < DEF_MAX_WAYS; w++) begin
                    valid_mem[s][w] = 1'b0;
                    dirty_mem[s][w] = 1'b0;
                    rank_mem[s][w] = RANK_OLDEST;
                end
            end
            blk_bits = RST_BLOCK_OFFSET_BITS;
            set_bits = RST_SET_INDEX_BITS;
            way_bits = RST_WAY_SELECT_BITS;
            expected_rsp_q.delete();
            pend_cnt = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BLOCK_OFFSET: blk_bits = i_cfg_data;
                    CFG_SET_INDEX: set_bits = i_cfg_data;
                    CFG_WAY_SELECT: way_bits = i_cfg_data[2:0];
                    default: ;
                endcase
            end
            // Responses go first so a response never matches an access taken at the same edge.
            if (i_out_valid && i_out_ready) begin
                check_rsp(i_out_data);
            end
            if (i_in_valid && i_in_ready) begin
                predict_access(i_in_data);
            end
        end
    end

endmodule

/* verif/set_assoc_writeback_lru_cache_level_unit_tb.sv */
// Testbench top for the set-associative write-back LRU cache level: it makes the
// access and configuration traffic and gives the verdict, while sawlc_access_checker
// predicts and compares. Depends on sawlc_pkg, the cache level and the checker.
module set_assoc_writeback_lru_cache_level_unit_tb;
    import sawlc_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int NUM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int POOL_MAX = DEF_MAX_WAYS + 2;
    localparam int RECENT_DEPTH = 16;
    localparam int SET_BITS_MAX = $clog2(DEF_MAX_SETS);
    localparam int WAY_BITS_MAX = $clog2(DEF_MAX_WAYS);
    // Register index that the block does not implement; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_cache_req i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_cache_rsp o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int hit_count;
    int miss_count;
    int evict_count;

    int send_gap_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int geometries = 1;

    // Current geometry, kept only to shape addresses that land in chosen sets.
    int cur_b = int'(RST_BLOCK_OFFSET_BITS);
    int cur_ib = int'(RST_SET_INDEX_BITS);
    int cur_sb = int'(RST_WAY_SELECT_BITS);

    logic [ADDR_W-1:0] tag_pool [POOL_MAX];
    int tag_pool_n = 1;
    int set_pool [4];
    logic [ADDR_W-1:0] recent_addr [RECENT_DEPTH];
    int recent_wr = 0;

    set_assoc_writeback_lru_cache_level_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    sawlc_access_checker checker_inst (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_hit_count(hit_count),
        .o_miss_count(miss_count),
        .o_evict_count(evict_count)
    );

    initial begin
        forever begin
            #(CLK_PERIOD / 2) i_clk = ~i_clk;
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("set_assoc_writeback_lru_cache_level_unit_tb: errors");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [ADDR_W-1:0] compose_addr(input logic [63:0] tag, input int set,
                                                        input logic [ADDR_W-1:0] off);
        logic [63:0] a;
        a = (tag << (cur_b + cur_ib))
            | ((64'(set) & ((64'd1 << cur_ib) - 64'd1)) << cur_b)
            | (64'(off) & ((64'd1 << cur_b) - 64'd1));
        return a[ADDR_W-1:0];
    endfunction

    function automatic t_cache_req mk_req(input logic wr, input logic [ADDR_W-1:0] addr);
        t_cache_req r;
        r.is_write = wr;
        r.access_address = addr;
        return r;
    endfunction

    // Valid is only lowered when a gap is taken, so back-to-back transactions keep it high.
    task automatic send_req(input t_cache_req req);
        bit took;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= req;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_in_ready;
            @(posedge i_clk);
        end
        items_sent++;
        recent_addr[recent_wr] = req.access_address;
        recent_wr = (recent_wr + 1) % RECENT_DEPTH;
    endtask

    task automatic wait_drain();
        bit empty;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        empty = 1'b0;
        while (!empty) begin
            @(negedge i_clk);
            empty = (pending == 0);
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        bit took;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_cfg_ready;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(input logic [3:0] blk, input logic [3:0] sets,
                                input logic [3:0] ways);
        wait_drain();
        repeat (4) @(posedge i_clk);
        write_reg(CFG_BLOCK_OFFSET, blk);
        write_reg(CFG_SET_INDEX, sets);
        write_reg(CFG_WAY_SELECT, ways);
        cur_b = int'(blk);
        cur_ib = (int'(sets) > SET_BITS_MAX) ? SET_BITS_MAX : int'(sets);
        cur_sb = (int'(ways[2:0]) > WAY_BITS_MAX) ? WAY_BITS_MAX : int'(ways[2:0]);
        geometries++;
    endtask

    // Two more tags than ways per set keep hits and evictions both frequent.
    task automatic refresh_pools();
        tag_pool_n = (1 << cur_sb) + 2;
        for (int i = 0; i < POOL_MAX; i++) begin
            if (i == 0) begin
                tag_pool[i] = '0;
            end else if ($urandom_range(1)) begin
                tag_pool[i] = ADDR_W'($urandom_range(7));
            end else begin
                tag_pool[i] = ADDR_W'({$urandom, $urandom});
            end
        end
        for (int i = 0; i < 4; i++) begin
            set_pool[i] = int'($urandom_range(DEF_MAX_SETS - 1));
        end
    endtask

    task automatic send_random();
        int sel;
        logic wr;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] off_mask;
        logic [ADDR_W-1:0] noise;
        sel = int'($urandom_range(99));
        wr = 1'($urandom_range(1));
        noise = ADDR_W'({$urandom, $urandom});
        off_mask = (48'd1 << cur_b) - 48'd1;
        if (sel < 12) begin
            addr = noise;
        end else if (sel < 35) begin
            addr = (recent_addr[$urandom_range(RECENT_DEPTH - 1)] & ~off_mask)
                   | (noise & off_mask);
        end else begin
            addr = compose_addr(64'(tag_pool[$urandom_range(tag_pool_n - 1)]),
                                set_pool[$urandom_range(3)], noise);
        end
        send_req(mk_req(wr, addr));
    endtask

    task automatic pick_phase(input int p, output logic [3:0] blk, output logic [3:0] sets,
                              output logic [3:0] ways, output t_idle_mode mode);
        case (p)
            0: begin blk = 4'd0; sets = 4'd0; ways = 4'd0; mode = IDLE_NONE; end
            1: begin blk = 4'd15; sets = 4'd15; ways = 4'd15; mode = IDLE_SEND; end
            2: begin blk = 4'd12; sets = 4'd10; ways = 4'd4; mode = IDLE_RECV; end
            3: begin blk = 4'd3; sets = 4'd2; ways = 4'd1; mode = IDLE_BOTH; end
            4: begin blk = 4'd4; sets = 4'd1; ways = 4'd3; mode = IDLE_NONE; end
            5: begin blk = 4'd9; sets = 4'd6; ways = 4'd12; mode = IDLE_SEND; end
            6: begin blk = 4'd6; sets = 4'd10; ways = 4'd2; mode = IDLE_RECV; end
            default: begin blk = 4'd1; sets = 4'd4; ways = 4'd5; mode = IDLE_BOTH; end
        endcase
    endtask

    initial begin
        logic [3:0] blk;
        logic [3:0] sets;
        logic [3:0] ways;
        t_idle_mode mode;
        for (int i = 0; i < RECENT_DEPTH; i++) begin
            recent_addr[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed accesses under the reset geometry: tag zero, the all-ones address,
        // a clean eviction, a dirty eviction and the eviction of the all-ones tag.
        send_req(mk_req(1'b0, '0));
        send_req(mk_req(1'b0, '0));
        send_req(mk_req(1'b1, '0));
        send_req(mk_req(1'b1, '1));
        send_req(mk_req(1'b0, '1));
        for (int t = 1; t <= 5; t++) begin
            send_req(mk_req(1'b0, compose_addr(64'(t), 7, '0)));
        end
        for (int t = 1; t <= 5; t++) begin
            send_req(mk_req(1'b1, compose_addr(64'(t), 5, ADDR_W'(t))));
        end
        for (int t = 2; t <= 5; t++) begin
            send_req(mk_req(1'b1, compose_addr(64'(t), DEF_MAX_SETS - 1, '0)));
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            pick_phase(p, blk, sets, ways, mode);
            set_geometry(blk, sets, ways);
            if (p == 3) begin
                write_reg(CFG_UNUSED_IDX, 4'hA);
            end
            refresh_pools();
            case (mode)
                IDLE_SEND: begin send_gap_pct = 78; stall_pct <= 0; end
                IDLE_RECV: begin send_gap_pct = 0; stall_pct <= 78; end
                IDLE_BOTH: begin send_gap_pct = 9; stall_pct <= 9; end
                default: begin send_gap_pct = 0; stall_pct <= 0; end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_random();
                if ($urandom_range(99) == 0) begin
                    wait_drain();
                end
            end
        end

        wait_drain();
        repeat (8) @(posedge i_clk);
        $display("Ran %0d accesses over %0d cache geometries with idle and stall phases:",
                 items_sent, geometries);
        $display("%0d hits, %0d misses, %0d dirty evictions written back.",
                 hit_count, miss_count, evict_count);
        if (fail_count == 0 && pending == 0) begin
            $display("set_assoc_writeback_lru_cache_level_unit_tb: clean");
        end else begin
            $display("set_assoc_writeback_lru_cache_level_unit_tb: errors");
        end
        $finish;
    end

endmodule
